// File: design/address_histogram_topk_core_macros.svh
// Assertion macros used by the checker file.
`ifndef ADDRESS_HISTOGRAM_TOPK_CORE_MACROS_SVH
`define ADDRESS_HISTOGRAM_TOPK_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define AHT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define AHT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: design/aht_pkg.sv
// Package: constants and types of the address histogram.
`default_nettype none
package aht_pkg;
    localparam int TABLE_DEPTH = 8192;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int USED_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [31:0] IMAGE_SPAN = 32'h0300_0000;
    localparam logic [6:0] MAX_REPORT = 7'd64;
    localparam logic [6:0] RESET_LIMIT = 7'd60;
    localparam logic [31:0] RESET_BASE = 32'h0040_0000;
    localparam int Q_DEPTH = 2;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    localparam logic [1:0] REG_IMAGE_BASE = 2'd0;
    localparam logic [1:0] REG_DECLARED_BASE = 2'd1;
    localparam logic [1:0] REG_REPORT_LIMIT = 2'd2;

    typedef struct packed {
        logic        command;
        logic [31:0] sample_address;
    } in_item_t;

    typedef struct packed {
        logic [6:0]  rank;
        logic [31:0] entry_address;
        logic [31:0] entry_count;
        logic        in_image;
        logic [31:0] static_address;
        logic        entry_valid;
        logic        last;
    } out_item_t;

    // Classified command handed from front to back
    typedef struct packed {
        logic        is_report;
        logic [31:0] address;
        logic [6:0]  limit;
    } job_t;
endpackage
`default_nettype wire

// File: design/aht_if.sv
// Valid/ready stream interfaces for the histogram channels.
`default_nettype none
interface aht_in_if import aht_pkg::*; (input wire logic clk);
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface aht_out_if import aht_pkg::*; (input wire logic clk);
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/aht_ram.sv
// Generic single-port-write, single-read RAM with registered read.
`default_nettype none
module aht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: design/aht_front.sv
// Front end: accepts transactions, classifies them and queues jobs.
`default_nettype none
module aht_front import aht_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    aht_in_if.sink     in_ch,
    input  wire logic [6:0] report_limit,
    output job_t       job,
    output logic       job_valid,
    input  wire logic  job_take
);
    localparam int QP_W = $clog2(Q_DEPTH);
    job_t            q_reg [Q_DEPTH];
    logic [QP_W-1:0] wp_reg, rp_reg;
    logic [QP_W:0]   cnt_reg;
    logic            push;
    job_t            cls;
    logic [6:0]      lim;

    // Clamp limit to 1..64
    always_comb
    begin
        lim = report_limit;
        if (lim == 7'd0)
        begin
            lim = 7'd1;
        end
        else if (lim > MAX_REPORT)
        begin
            lim = MAX_REPORT;
        end
        cls.is_report = (in_ch.data.command == CMD_REPORT);
        cls.address = in_ch.data.sample_address;
        cls.limit = lim;
    end

    assign in_ch.ready = (cnt_reg != (QP_W+1)'(Q_DEPTH));
    assign push = in_ch.valid && in_ch.ready;
    assign job = q_reg[rp_reg];
    assign job_valid = (cnt_reg != '0);

    // Job queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (job_take)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QP_W+1)'(push) - (QP_W+1)'(job_take);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= cls;
        end
    end
endmodule
`default_nettype wire

// File: design/aht_back.sv
// Back end: table scan for samples and ranked selection for reports.
`default_nettype none
module aht_back import aht_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  job_t       job,
    input  wire logic  job_valid,
    output logic       job_take,
    input  wire logic [31:0] image_base,
    input  wire logic [31:0] declared_base,
    aht_out_if.source  out_ch
);
    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_ADD_WR, S_RANK, S_FETCH, S_EMIT
    } state_t;

    state_t            state_reg;
    job_t              job_reg;
    logic [USED_W-1:0] used_reg;
    logic [USED_W-1:0] i_reg;
    logic              rd_ok_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              hit_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [31:0]       best_cnt_reg;
    logic [31:0]       prev_cnt_reg;
    logic [IDX_W-1:0]  prev_idx_reg;
    logic [6:0]        rank_reg;
    logic [6:0]        top_reg;
    logic [1:0]        wait_reg;
    logic              ovalid_reg;
    out_item_t         odata_reg;

    logic              we;
    logic [IDX_W-1:0]  waddr, raddr;
    logic [31:0]       wcnt, waddr_data;
    logic [31:0]       rd_addr, rd_cnt;
    logic [32:0]       span_end;
    logic              in_span;

    aht_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_addr_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(waddr_data),
        .raddr(raddr), .rdata(rd_addr)
    );
    aht_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_count_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wcnt),
        .raddr(raddr), .rdata(rd_cnt)
    );

    // Write port: bump on hit, append on miss
    always_comb
    begin
        we = (state_reg == S_ADD_WR) && (hit_reg || (used_reg != USED_W'(TABLE_DEPTH)));
        waddr = hit_reg ? hit_idx_reg : used_reg[IDX_W-1:0];
        waddr_data = job_reg.address;
        wcnt = hit_reg ? ((best_cnt_reg == 32'hFFFF_FFFF) ? best_cnt_reg
                                                          : best_cnt_reg + 32'd1)
                       : 32'd1;
        raddr = (state_reg == S_FETCH) ? best_idx_reg : i_reg[IDX_W-1:0];
    end

    assign span_end = {1'b0, image_base} + {1'b0, IMAGE_SPAN};
    assign in_span = (rd_addr >= image_base) && ({1'b0, rd_addr} < span_end);

    assign job_take = (state_reg == S_IDLE) && job_valid && !ovalid_reg;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data = odata_reg;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg <= '0;
            ovalid_reg <= 1'b0;
            i_reg <= '0;
            rd_ok_reg <= 1'b0;
            hit_reg <= 1'b0;
            found_reg <= 1'b0;
            rank_reg <= '0;
            top_reg <= '0;
            wait_reg <= '0;
        end
        else
        begin
            if (ovalid_reg && out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
            rd_ok_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_take)
                    begin
                        job_reg <= job;
                        i_reg <= '0;
                        hit_reg <= 1'b0;
                        found_reg <= 1'b0;
                        rank_reg <= 7'd1;
                        if (!job.is_report)
                        begin
                            state_reg <= S_SCAN;
                        end
                        else if (used_reg == '0)
                        begin
                            ovalid_reg <= 1'b1;
                            odata_reg <= '{rank: 7'd1, entry_address: '0,
                                entry_count: '0, in_image: 1'b0,
                                static_address: '0, entry_valid: 1'b0, last: 1'b1};
                        end
                        else
                        begin
                            top_reg <= (used_reg < USED_W'(job.limit))
                                ? 7'(used_reg) : job.limit;
                            state_reg <= S_RANK;
                        end
                    end
                end
                S_SCAN:
                begin
                    // one read issued per cycle, compared in the next cycle
                    if (i_reg < used_reg && !hit_reg)
                    begin
                        rd_ok_reg <= 1'b1;
                        rd_idx_reg <= i_reg[IDX_W-1:0];
                        i_reg <= i_reg + 1'b1;
                    end
                    else if (!rd_ok_reg)
                    begin
                        state_reg <= S_ADD_WR;
                    end
                    if (rd_ok_reg && !hit_reg && rd_addr == job_reg.address)
                    begin
                        hit_reg <= 1'b1;
                        hit_idx_reg <= rd_idx_reg;
                        best_cnt_reg <= rd_cnt;
                    end
                end
                S_ADD_WR:
                begin
                    if (!hit_reg && used_reg != USED_W'(TABLE_DEPTH))
                    begin
                        used_reg <= used_reg + 1'b1;
                    end
                    state_reg <= S_IDLE;
                end
                S_RANK:
                begin
                    if (i_reg < used_reg)
                    begin
                        rd_ok_reg <= 1'b1;
                        rd_idx_reg <= i_reg[IDX_W-1:0];
                        i_reg <= i_reg + 1'b1;
                    end
                    else if (!rd_ok_reg)
                    begin
                        state_reg <= S_FETCH;
                        wait_reg <= '0;
                    end
                    if (rd_ok_reg && (rank_reg == 7'd1 || rd_cnt < prev_cnt_reg
                        || (rd_cnt == prev_cnt_reg && rd_idx_reg > prev_idx_reg))
                        && (!found_reg || rd_cnt > best_cnt_reg))
                    begin
                        found_reg <= 1'b1;
                        best_idx_reg <= rd_idx_reg;
                        best_cnt_reg <= rd_cnt;
                    end
                end
                S_FETCH:
                begin
                    // read the winner, wait for the output register to drain
                    if (wait_reg != 2'd2)
                    begin
                        wait_reg <= wait_reg + 1'b1;
                    end
                    else if (!ovalid_reg || out_ch.ready)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    ovalid_reg <= 1'b1;
                    odata_reg <= '{rank: rank_reg, entry_address: rd_addr,
                        entry_count: rd_cnt, in_image: in_span,
                        static_address: in_span ? rd_addr - image_base + declared_base
                                                : 32'd0,
                        entry_valid: 1'b1, last: (rank_reg == top_reg)};
                    prev_cnt_reg <= best_cnt_reg;
                    prev_idx_reg <= best_idx_reg;
                    found_reg <= 1'b0;
                    i_reg <= '0;
                    rank_reg <= rank_reg + 7'd1;
                    state_reg <= (rank_reg == top_reg) ? S_IDLE : S_RANK;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// File: design/address_histogram_topk_core.sv
// Top level of the sampled-address histogram with ranked report.
// A sample runs one table scan through a single RAM read port to find the address,
// then one write updates or appends it. A report runs, for each rank, a full
// scan that selects the next busiest entry after the previous one, and can be
// held up while the output stage stalls.
// The table is not cleared at reset; a
// fill count bounds the scans. A two-entry job queue decouples input handshake
// from the scanning engine; results leave through a registered output stage.
`default_nettype none
module address_histogram_topk_core import aht_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    aht_in_if.sink           in_ch,
    aht_out_if.source        out_ch,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    logic [31:0] image_base_reg, declared_base_reg;
    logic [6:0]  report_limit_reg;
    job_t        job;
    logic        job_valid, job_take;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_base_reg <= RESET_BASE;
            declared_base_reg <= RESET_BASE;
            report_limit_reg <= RESET_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_BASE: image_base_reg <= cfg_data;
                REG_DECLARED_BASE: declared_base_reg <= cfg_data;
                REG_REPORT_LIMIT: report_limit_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    aht_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .report_limit(report_limit_reg),
        .job(job), .job_valid(job_valid), .job_take(job_take)
    );
    aht_back u_back (
        .clk(clk), .rst_n(rst_n), .job(job), .job_valid(job_valid),
        .job_take(job_take), .image_base(image_base_reg),
        .declared_base(declared_base_reg), .out_ch(out_ch)
    );
endmodule
`default_nettype wire

// File: design/aht_checker.sv
// Port-level checker for the histogram core, bound to the top level.
`default_nettype none
`include "address_histogram_topk_core_macros.svh"
module aht_checker import aht_pkg::*; (
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_item_t out_data
);
    // Stalled result holds
    `AHT_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    // Empty-table result is the only one of its report
    `AHT_ASSERT_IMP(a_empty, out_valid && !out_data.entry_valid, out_data.last && out_data.rank == 7'd1)
    // Rank stays in range
    `AHT_ASSERT_IMP(a_rank, out_valid, out_data.rank != 7'd0 && out_data.rank <= MAX_REPORT)
    // Outside the image the rebased address is zero
    `AHT_ASSERT_IMP(a_static, out_valid && !out_data.in_image, out_data.static_address == 32'd0)
endmodule

bind address_histogram_topk_core aht_checker u_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire

// File: tb/tb.sv
// Testbench for the sampled-address histogram with ranked report.
module tb;
    import aht_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam logic [32:0] SPAN_33 = {1'b0, IMAGE_SPAN};

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    aht_in_if  in_ch (clk);
    aht_out_if out_ch (clk);

    address_histogram_topk_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted histogram and register copies
    logic [31:0] hist_addr[$];
    logic [31:0] hist_count[$];
    logic [31:0] cur_image_base;
    logic [31:0] cur_declared_base;
    logic [6:0]  cur_limit;

    out_item_t   ranked_entries[$];
    int          mismatches;
    int          cycles;
    bit          quiet;
    logic [31:0] addr_pool[20];

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Cycle counter and timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: ready with random stall bursts
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // Result checker: each transaction against the oldest expectation
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (ranked_entries.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result rank=%0d addr=%h", got.rank, got.entry_address);
            end
            else
            begin
                want = ranked_entries.pop_front();
                if (got.rank !== want.rank || got.entry_address !== want.entry_address ||
                    got.entry_count !== want.entry_count || got.in_image !== want.in_image ||
                    got.static_address !== want.static_address ||
                    got.entry_valid !== want.entry_valid || got.last !== want.last)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                    begin
                        $display("mismatch exp r=%0d a=%h c=%0d i=%b s=%h v=%b l=%b",
                                 want.rank, want.entry_address, want.entry_count,
                                 want.in_image, want.static_address, want.entry_valid,
                                 want.last);
                        $display("         got r=%0d a=%h c=%0d i=%b s=%h v=%b l=%b",
                                 got.rank, got.entry_address, got.entry_count,
                                 got.in_image, got.static_address, got.entry_valid,
                                 got.last);
                    end
                end
            end
        end
    end

    // Sample counting on the predicted table
    function automatic void count_sample(logic [31:0] addr);
        foreach (hist_addr[i])
            if (hist_addr[i] == addr)
            begin
                if (hist_count[i] != 32'hFFFF_FFFF)
                    hist_count[i] = hist_count[i] + 32'd1;
                return;
            end
        if (hist_addr.size() < TABLE_DEPTH)
        begin
            hist_addr.push_back(addr);
            hist_count.push_back(32'd1);
        end
    endfunction

    // Ranked report: descending count, earlier insertion wins ties
    function automatic void rank_entries();
        int          lim;
        int          top;
        int          best;
        bit          found;
        logic [31:0] prev_cnt;
        int          prev_idx;
        logic [32:0] a33;
        out_item_t   e;
        lim = (cur_limit == 0) ? 1 : ((cur_limit > MAX_REPORT) ? MAX_REPORT : cur_limit);
        if (hist_addr.size() == 0)
        begin
            e = '0;
            e.rank = 7'd1;
            e.last = 1'b1;
            ranked_entries.push_back(e);
            return;
        end
        top = (hist_addr.size() < lim) ? hist_addr.size() : lim;
        prev_cnt = 0;
        prev_idx = 0;
        for (int r = 0; r < top; r++)
        begin
            found = 0;
            best = 0;
            for (int i = 0; i < hist_addr.size(); i++)
            begin
                if (r != 0 && !(hist_count[i] < prev_cnt ||
                                (hist_count[i] == prev_cnt && i > prev_idx)))
                    continue;
                if (!found || hist_count[i] > hist_count[best])
                begin
                    best = i;
                    found = 1;
                end
            end
            prev_cnt = hist_count[best];
            prev_idx = best;
            a33 = {1'b0, hist_addr[best]};
            e.rank = 7'(r + 1);
            e.entry_address = hist_addr[best];
            e.entry_count = hist_count[best];
            e.in_image = (a33 >= {1'b0, cur_image_base}) &&
                         (a33 < {1'b0, cur_image_base} + SPAN_33);
            e.static_address = e.in_image ?
                hist_addr[best] - cur_image_base + cur_declared_base : 32'd0;
            e.entry_valid = 1'b1;
            e.last = (r + 1 == top);
            ranked_entries.push_back(e);
        end
    endfunction

    // Send one command; valid stays high so a following send needs no lowering
    task automatic send_item(logic cmd, logic [31:0] addr);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data.command <= cmd;
        in_ch.data.sample_address <= addr;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        if (cmd == CMD_ADD)
            count_sample(addr);
        else
            rank_entries();
    endtask

    // Drop valid, wait for all results, then let a pending scan finish
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (ranked_entries.size() != 0) @(posedge clk);
        repeat (4 * (hist_addr.size() + 12) + 40) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_IMAGE_BASE:    cur_image_base = value;
            REG_DECLARED_BASE: cur_declared_base = value;
            REG_REPORT_LIMIT:  cur_limit = value[6:0];
            default: ;
        endcase
    endtask

    // Report straight after reset: the empty-table result
    task automatic test_empty_report();
        send_item(CMD_REPORT, 32'hFFFF_FFFF);
        settle();
    endtask

    // Image edges, ties, limit zero and limit above the maximum
    task automatic test_directed();
        send_item(CMD_ADD, RESET_BASE);
        send_item(CMD_ADD, RESET_BASE + IMAGE_SPAN - 1);
        send_item(CMD_ADD, RESET_BASE + IMAGE_SPAN);
        send_item(CMD_ADD, RESET_BASE - 1);
        send_item(CMD_ADD, 32'h0000_0000);
        send_item(CMD_ADD, 32'hFFFF_FFFF);
        send_item(CMD_ADD, 32'h0000_0000);
        send_item(CMD_ADD, RESET_BASE - 1);
        send_item(CMD_ADD, 32'hFFFF_FFFF);
        send_item(CMD_ADD, 32'hFFFF_FFFF);
        send_item(CMD_REPORT, 32'h0);
        send_item(CMD_REPORT, 32'h1234_5678);
        settle();
        write_reg(REG_REPORT_LIMIT, 32'd0);
        send_item(CMD_REPORT, 32'h0);
        settle();
        write_reg(REG_REPORT_LIMIT, 32'h7F);
        send_item(CMD_REPORT, 32'h0);
        settle();
        // span clipped at the top of the address space, rebase wraps
        write_reg(REG_IMAGE_BASE, 32'hFFFF_0000);
        write_reg(REG_DECLARED_BASE, 32'hFFFF_FFFF);
        send_item(CMD_ADD, 32'hFFFF_0000);
        send_item(CMD_ADD, 32'hFFFE_FFFF);
        send_item(CMD_REPORT, 32'h0);
        settle();
        write_reg(REG_IMAGE_BASE, 32'h0);
        write_reg(REG_DECLARED_BASE, 32'h0);
        send_item(CMD_REPORT, 32'h0);
        settle();
    endtask

    // Random samples from a small address pool, reports among them
    task automatic test_random();
        logic [31:0] a;
        for (int i = 0; i < 20; i++)
            addr_pool[i] = (i < 8) ? RESET_BASE + $urandom_range(0, IMAGE_SPAN - 1) : $urandom;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: write_reg(REG_REPORT_LIMIT, 32'd1);
                1: write_reg(REG_REPORT_LIMIT, 32'd64);
                default: write_reg(REG_REPORT_LIMIT, $urandom_range(1, 64));
            endcase
            write_reg(REG_IMAGE_BASE, (ph == 0) ? RESET_BASE : $urandom);
            write_reg(REG_DECLARED_BASE, (ph == 1) ? 32'hFFFF_FFFF : $urandom);
            for (int n = 0; n < 4; n++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_item(CMD_REPORT, $urandom);
                else
                begin
                    a = ($urandom_range(0, 7) == 0) ? $urandom
                                                     : addr_pool[$urandom_range(0, 19)];
                    send_item(CMD_ADD, a);
                end
            end
            send_item(CMD_REPORT, $urandom);
            settle();
        end
    endtask

    // More distinct entries than the widest report, without idling
    task automatic test_wide_report();
        quiet = 1;
        write_reg(REG_IMAGE_BASE, RESET_BASE);
        write_reg(REG_DECLARED_BASE, 32'h1000_0000);
        write_reg(REG_REPORT_LIMIT, 32'd64);
        for (int i = 0; i < 65; i++)
            send_item(CMD_ADD, RESET_BASE + 32'h100 * i);
        send_item(CMD_REPORT, 32'h0);
        settle();
        write_reg(REG_REPORT_LIMIT, 32'h7F);
        send_item(CMD_REPORT, 32'h0);
        settle();
    endtask

    // Sequence
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_IMAGE_BASE;
        cfg_data = 32'h0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cycles = 0;
        mismatches = 0;
        quiet = 0;
        cur_image_base = RESET_BASE;
        cur_declared_base = RESET_BASE;
        cur_limit = RESET_LIMIT;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_report();
        test_directed();
        test_random();
        test_wide_report();

        repeat (200) @(posedge clk);
        if (mismatches == 0 && ranked_entries.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
